@@ design/bbe_pkg.sv @@
// ---------------------------------------------------------------------------
// bbe_pkg - shared types and constants
// Field widths, codes and the divider interface of the B-spline basis block.
// ---------------------------------------------------------------------------
package bbe_pkg;

  // item fields
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 17;
  localparam int COORD_W = 32;
  localparam int SLOT_W  = 6;
  localparam int IN_DATA_W  = 40;   // slot + coordinate, padded to bytes
  localparam int OUT_DATA_W = 24;   // index + value, padded to bytes

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CNT_W      = 7;
  localparam int ORD_W      = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLINE_ORDER = 2'd1;

  // func codes
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  localparam logic [VAL_W-1:0] UNIT = 17'd65536;

  // datapath widths: knots kept at twice their value
  localparam int KNOT_W = COORD_W + 1;
  localparam int DIFF_W = KNOT_W + 1;
  localparam int PROD_W = DIFF_W + VAL_W + 1;
  localparam int DEN_W  = DIFF_W;
  localparam int NQ_W   = PROD_W + 2;
  localparam int QUO_W  = NQ_W + 1;
  localparam int ACC_W  = QUO_W + 1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/bspline_basis_eval.sv @@
// ---------------------------------------------------------------------------
// bspline_basis_eval - B-spline basis evaluator
// Clamped knots from stored samples, span search, Cox-de Boor recursion.
// ---------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | s_tuser: func; s_tdata: slot, coordinate
//  m_      | out | m_tvalid/tready  | m_tuser: span_found; m_tlast: last;
//          |     |                  | m_tdata: basis_index, basis_value
//  cfg_    | in  | cfg_we           | cfg_index, cfg_data
//
//  An evaluate runs a span search (two sample-memory reads per knot), then
//  k*(k+1)/2-1 recursion steps (four knot fetches and up to two passes through
//  the bit-serial divider each), then emits its results one by one.
//  Items are taken one at a time; an evaluate's results leave through one
//  output register, so the next item is taken once the last result is loaded.
//  rst is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
module bspline_basis_eval #(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_ORDER   = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic                               s_tuser,   // func
  input  logic [bbe_pkg::IN_DATA_W-1:0]      s_tdata,   // sample_slot, coordinate
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic                               m_tuser,   // span_found
  output logic                               m_tlast,
  output logic [bbe_pkg::OUT_DATA_W-1:0]     m_tdata,   // basis_index, basis_value
  input  logic                               cfg_we,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bbe_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int NCW = $clog2(MAX_SAMPLES + 1);
  localparam int KW  = $clog2(MAX_ORDER + 1);
  localparam int MW  = $clog2(MAX_SAMPLES + 2 * MAX_ORDER + 2) + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_KA, S_KB, S_KC, S_SPAN, S_SPEND, S_NOSPAN, S_INIT, S_STEP,
    S_MUL, S_D1, S_W1, S_D2, S_W2, S_WB, S_ORD, S_OLD
  } state_t;

  typedef enum logic [2:0] {KD_SPAN, KD_QA, KD_QB, KD_QC, KD_QD} kdst_t;

  state_t state;
  kdst_t  kdst;

  // configuration
  logic [CNT_W-1:0] sample_count;
  logic [ORD_W-1:0] spline_order;
  logic [NCW-1:0]   n_eff;
  logic [KW-1:0]    k_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= CNT_W'(64);
      spline_order <= ORD_W'(4);
    end else if (cfg_we) begin
      if (cfg_index == CFG_SAMPLE_COUNT) sample_count <= cfg_data[CNT_W-1:0];
      else if (cfg_index == CFG_SPLINE_ORDER) spline_order <= cfg_data[ORD_W-1:0];
    end
  end

  always_comb begin
    if (sample_count < CNT_W'(2)) n_eff = NCW'(2);
    else if (32'(sample_count) > MAX_SAMPLES) n_eff = NCW'(MAX_SAMPLES);
    else n_eff = NCW'(sample_count);
    if (spline_order < ORD_W'(1)) k_eff = KW'(1);
    else if (32'(spline_order) > MAX_ORDER) k_eff = KW'(MAX_ORDER);
    else k_eff = KW'(spline_order);
  end

  // sample memory
  logic [COORD_W-1:0] smem [MAX_SAMPLES];
  logic               swe;
  logic [AW-1:0]      swaddr;
  logic [AW-1:0]      sraddr;
  logic [COORD_W-1:0] srdata;

  always_ff @(posedge clk) begin
    if (swe) smem[swaddr] <= s_tdata[SLOT_W +: COORD_W];
    srdata <= smem[sraddr];
  end

  // basis scratch memory
  logic [VAL_W-1:0] scr [MAX_ORDER + 1];
  logic             scr_we;
  logic [KW-1:0]    scr_waddr;
  logic [VAL_W-1:0] scr_wdata;
  logic             sren;
  logic [KW-1:0]    sraddr_b;
  logic [VAL_W-1:0] sdata;

  always_ff @(posedge clk) begin
    if (scr_we) scr[scr_waddr] <= scr_wdata;
    if (sren) sdata <= scr[sraddr_b];
  end

  // working registers
  logic signed [KNOT_W-1:0] t2, p, kv, qa, qb, qc, qd;
  logic signed [COORD_W-1:0] ktmp;
  logic signed [MW-1:0]     m;
  logic [NCW-1:0]           i, kset;
  logic                     first;
  logic [KW-1:0]            j, d;
  logic [VAL_W-1:0]         cur;
  logic signed [PROD_W-1:0] p1, p2;
  logic signed [ACC_W-1:0]  acc;

  // knot address: clamp index, then pick the two samples summed
  logic signed [MW-1:0] mc, ms_k, ms_n;
  logic [AW-1:0]        a1, a2;
  always_comb begin
    mc   = (m < MW'(1)) ? MW'(1) : m;
    ms_k = $signed(MW'(k_eff));
    ms_n = $signed(MW'(n_eff));
    if (mc <= ms_k) begin
      a1 = '0;
      a2 = '0;
    end else if (mc > ms_n) begin
      a1 = AW'(ms_n - MW'(1));
      a2 = AW'(ms_n - MW'(1));
    end else begin
      a1 = AW'(mc - ms_k - MW'(1));
      a2 = AW'(mc - MW'(1));
    end
  end

  // basis index of the current recursion step
  logic signed [MW-1:0] bi, jm, oidx;
  always_comb begin
    bi   = $signed(MW'(kset)) - $signed(MW'(k_eff)) + MW'(1) + $signed(MW'(d));
    jm   = $signed(MW'(j));
    oidx = $signed(MW'(kset)) - $signed(MW'(k_eff)) + $signed(MW'(d));
  end

  logic [VAL_W-1:0]         nxt;
  logic signed [KNOT_W:0]   kv_tol;
  logic signed [DEN_W-1:0]  den1, den2;
  logic signed [ACC_W-1:0]  acc_sat;
  always_comb begin
    nxt    = ((KW+1)'(d) + (KW+1)'(1) == (KW+1)'(k_eff)) ? '0 : sdata;
    kv_tol = (KNOT_W+1)'(kv) + (KNOT_W+1)'(2);
    den1   = DEN_W'(qa) - DEN_W'(qb);
    den2   = DEN_W'(qc) - DEN_W'(qd);
    if (acc < 0) acc_sat = '0;
    else if (acc > ACC_W'(UNIT)) acc_sat = ACC_W'(UNIT);
    else acc_sat = acc;
  end

  // divider
  logic                     div_start;
  logic signed [PROD_W-1:0] div_num;
  logic signed [DEN_W-1:0]  div_den;
  logic signed [QUO_W-1:0]  div_quo;
  div_stat_t                div_stat;

  assign div_start = (state == S_D1 && qa != qb) || (state == S_D2 && qd != qc);
  assign div_num   = (state == S_D1) ? p1 : p2;
  assign div_den   = (state == S_D1) ? den1 : den2;

  bbe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  logic out_free;
  logic out_load;
  assign out_free = !m_tvalid || m_tready;
  // a result enters the output register this cycle
  assign out_load = ((state == S_NOSPAN) || (state == S_OLD)) && out_free;
  assign s_tready = (state == S_IDLE);

  // memory port control
  always_comb begin
    swe       = (state == S_IDLE) && s_tvalid && s_tuser == FUNC_STORE
                && 32'(s_tdata[SLOT_W-1:0]) < MAX_SAMPLES;
    swaddr    = AW'(s_tdata[SLOT_W-1:0]);
    sraddr    = (state == S_KB) ? a2 : a1;
    sren      = (state == S_STEP) || (state == S_ORD);
    sraddr_b  = (state == S_STEP) ? KW'((KW+1)'(d) + (KW+1)'(1)) : d;
    scr_we    = (state == S_INIT) || (state == S_WB);
    scr_waddr = (state == S_INIT) ? KW'(k_eff - KW'(1)) : d;
    scr_wdata = (state == S_INIT) ? UNIT : VAL_W'(acc_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser == FUNC_EVAL) begin
            t2    <= KNOT_W'({s_tdata[SLOT_W +: COORD_W], 1'b0});
            i     <= NCW'(1);
            kset  <= '0;
            first <= 1'b1;
            m     <= MW'(1);
            kdst  <= KD_SPAN;
            state <= S_KA;
          end
        end
        S_KA: state <= S_KB;
        S_KB: begin
          ktmp  <= srdata;
          state <= S_KC;
        end
        S_KC: begin
          case (kdst)
            KD_SPAN: begin
              kv    <= KNOT_W'(ktmp) + KNOT_W'($signed(srdata));
              state <= S_SPAN;
            end
            KD_QA: begin
              qa    <= KNOT_W'(ktmp) + KNOT_W'($signed(srdata));
              kdst  <= KD_QB;
              m     <= bi + MW'(1);
              state <= S_KA;
            end
            KD_QB: begin
              qb    <= KNOT_W'(ktmp) + KNOT_W'($signed(srdata));
              kdst  <= KD_QC;
              m     <= bi + jm - MW'(1);
              state <= S_KA;
            end
            KD_QC: begin
              qc    <= KNOT_W'(ktmp) + KNOT_W'($signed(srdata));
              kdst  <= KD_QD;
              m     <= bi;
              state <= S_KA;
            end
            default: begin
              qd    <= KNOT_W'(ktmp) + KNOT_W'($signed(srdata));
              state <= S_MUL;
            end
          endcase
        end
        // p holds q(i), kv holds q(i+1)
        S_SPAN: begin
          if (first) begin
            p     <= kv;
            first <= 1'b0;
            m     <= MW'(2);
            state <= S_KA;
          end else begin
            if (i == n_eff && p <= t2 && (KNOT_W+1)'(t2) <= kv_tol) kset <= i;
            else if (p <= t2 && t2 < kv) kset <= i;
            if (i == n_eff) begin
              state <= S_SPEND;
            end else begin
              p     <= kv;
              i     <= i + NCW'(1);
              m     <= $signed(MW'(i)) + MW'(2);
              state <= S_KA;
            end
          end
        end
        S_SPEND: state <= (kset == '0) ? S_NOSPAN : S_INIT;
        S_NOSPAN: begin
          if (out_free) begin
            m_tdata  <= '0;
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_INIT: begin
          j   <= KW'(2);
          cur <= '0;
          if (k_eff == KW'(1)) begin
            d     <= '0;
            state <= S_ORD;
          end else begin
            d     <= k_eff - KW'(2);
            state <= S_STEP;
          end
        end
        // fetch B(d+1) and the four knots of this step
        S_STEP: begin
          m     <= bi + jm;
          kdst  <= KD_QA;
          state <= S_KA;
        end
        S_MUL: begin
          p1    <= PROD_W'(DIFF_W'(qa) - DIFF_W'(t2)) * $signed({1'b0, nxt});
          p2    <= PROD_W'(DIFF_W'(t2) - DIFF_W'(qd)) * $signed({1'b0, cur});
          acc   <= '0;
          state <= S_D1;
        end
        S_D1: state <= (qa != qb) ? S_W1 : S_D2;
        S_W1: begin
          if (div_stat.done) begin
            acc   <= ACC_W'(div_quo);
            state <= S_D2;
          end
        end
        S_D2: state <= (qd != qc) ? S_W2 : S_WB;
        S_W2: begin
          if (div_stat.done) begin
            acc   <= acc + ACC_W'(div_quo);
            state <= S_WB;
          end
        end
        S_WB: begin
          if (d == k_eff - KW'(1)) begin
            if (j == k_eff) begin
              d     <= '0;
              state <= S_ORD;
            end else begin
              j     <= j + KW'(1);
              d     <= k_eff - j - KW'(1);
              cur   <= '0;
              state <= S_STEP;
            end
          end else begin
            cur   <= nxt;
            d     <= d + KW'(1);
            state <= S_STEP;
          end
        end
        S_ORD: state <= S_OLD;
        S_OLD: begin
          if (out_free) begin
            m_tdata  <= OUT_DATA_W'({sdata, IDX_W'(oidx)});
            m_tuser  <= 1'b1;
            m_tlast  <= (d == k_eff - KW'(1));
            if (d == k_eff - KW'(1)) begin
              state <= S_IDLE;
            end else begin
              d     <= d + KW'(1);
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_nospan_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[IDX_W +: VAL_W] == '0)
    else $error("out-of-range result malformed");
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[IDX_W +: VAL_W] <= UNIT)
    else $error("basis value above one");
  a_scr_addr: assert property (@(posedge clk) disable iff (rst)
    scr_we |-> scr_waddr < k_eff)
    else $error("scratch write beyond order");
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
`endif

endmodule

@@ design/bbe_div.sv @@
// ---------------------------------------------------------------------------
// bbe_div - rounding signed divider
// Restoring division, one quotient bit per cycle; rounds to nearest with
// ties away from zero.
// ---------------------------------------------------------------------------
module bbe_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [bbe_pkg::PROD_W-1:0] num,
  input  logic signed [bbe_pkg::DEN_W-1:0]  den,
  output logic signed [bbe_pkg::QUO_W-1:0]  quo,
  output bbe_pkg::div_stat_t                stat
);
  import bbe_pkg::*;

  localparam int CW = $clog2(NQ_W + 1);

  logic signed [PROD_W:0] num_x;
  logic signed [DEN_W:0]  den_x;
  logic [PROD_W:0]        an;
  logic [DEN_W:0]         ad;
  logic [NQ_W-1:0]        nval;
  logic [DEN_W+1:0]       dval;
  logic [DEN_W+2:0]       sh;

  logic [NQ_W-1:0]  dvd;
  logic [DEN_W+1:0] dsr;
  logic [DEN_W+1:0] rem;
  logic             neg;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;

  always_comb begin
    num_x = (PROD_W+1)'(num);
    den_x = (DEN_W+1)'(den);
    an    = num_x[PROD_W] ? (PROD_W+1)'(-num_x) : num_x;
    ad    = den_x[DEN_W] ? (DEN_W+1)'(-den_x) : den_x;
    nval  = NQ_W'({an, 1'b0}) + NQ_W'(ad);
    dval  = {ad, 1'b0};
    sh    = {rem, dvd[NQ_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        dvd  <= nval;
        dsr  <= dval;
        rem  <= '0;
        neg  <= num[PROD_W-1] ^ den[DEN_W-1];
        cnt  <= CW'(NQ_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (sh >= {1'b0, dsr}) begin
          rem <= (DEN_W+2)'(sh - {1'b0, dsr});
          dvd <= {dvd[NQ_W-2:0], 1'b1};
        end else begin
          rem <= sh[DEN_W+1:0];
          dvd <= {dvd[NQ_W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quo       = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  assign stat.busy = busy;
  assign stat.done = done;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done longer than one cycle");
`endif

endmodule
